// ===== hdl/wtsp_pkg.sv =====
`default_nettype none

package wtsp_pkg;

   // width of one viewport dimension register
   localparam int unsigned DIM_WIDTH = 14;

   // register reset values
   localparam logic [DIM_WIDTH-1:0] SCREEN_WIDTH_RESET  = 14'd1024;
   localparam logic [DIM_WIDTH-1:0] SCREEN_HEIGHT_RESET = 14'd768;

   // register indexes of the csr port
   localparam logic [3:0] CSR_X_FIRST  = 4'd0;
   localparam logic [3:0] CSR_X_SECOND = 4'd1;
   localparam logic [3:0] CSR_Y_FIRST  = 4'd2;
   localparam logic [3:0] CSR_Y_SECOND = 4'd3;
   localparam logic [3:0] CSR_W_FIRST  = 4'd4;
   localparam logic [3:0] CSR_W_SECOND = 4'd5;
   localparam logic [3:0] CSR_WIDTH    = 4'd6;
   localparam logic [3:0] CSR_HEIGHT   = 4'd7;

   // sideband that travels with an item through the divider
   typedef struct packed {
      logic       visible;
      logic [1:0] neg;      // sign of the numerator, lane 0 is x, lane 1 is y
   } side_type;

endpackage

`default_nettype wire

// ===== hdl/wtsp_divpipe.sv =====
`default_nettype none

module wtsp_divpipe #(
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         in_valid,
   output logic                                        in_ready,
   input  wire  [2*COORD_WIDTH-FRAC_BITS+3+wtsp_pkg::DIM_WIDTH+FRAC_BITS-1:0] in_num_x,
   input  wire  [2*COORD_WIDTH-FRAC_BITS+3+wtsp_pkg::DIM_WIDTH+FRAC_BITS-1:0] in_num_y,
   input  wire  [2*COORD_WIDTH-FRAC_BITS+1:0]          in_den,
   input  wire  wtsp_pkg::side_type                    in_side,
   output logic                                        out_valid,
   input  wire                                         out_ready,
   output logic [COORD_WIDTH-1:0]                      out_x,
   output logic [COORD_WIDTH-1:0]                      out_y,
   output logic                                        out_visible
);

   localparam int unsigned CS   = 2*COORD_WIDTH - FRAC_BITS + 2;
   localparam int unsigned MW   = CS + 1;
   localparam int unsigned DW   = CS;
   localparam int unsigned NW   = MW + wtsp_pkg::DIM_WIDTH + FRAC_BITS;
   localparam int unsigned QW   = COORD_WIDTH + 1;
   localparam int unsigned LAST = QW + 1;
   localparam logic [QW-1:0] NEG_LIMIT = QW'(1) << (COORD_WIDTH - 1);
   localparam logic [QW-1:0] POS_LIMIT = NEG_LIMIT - QW'(1);

   logic                adv;
   logic [LAST:0]       v_ff, v_in;
   logic [DW-1:0]       rem_ff [0:1][0:QW];
   logic [DW-1:0]       rem_in [0:1][0:QW];
   logic [QW-1:0]       nlo_ff [0:1][0:QW];
   logic [QW-1:0]       nlo_in [0:1][0:QW];
   logic [QW-1:0]       q_ff   [0:1][0:QW];
   logic [QW-1:0]       q_in   [0:1][0:QW];
   logic                ovf_ff [0:1][0:QW];
   logic                ovf_in [0:1][0:QW];
   logic [DW-1:0]       d_ff   [0:QW];
   logic [DW-1:0]       d_in   [0:QW];
   wtsp_pkg::side_type  side_ff [0:QW];
   wtsp_pkg::side_type  side_in [0:QW];
   logic [COORD_WIDTH-1:0] res_ff [0:1];
   logic [COORD_WIDTH-1:0] res_in [0:1];
   logic                vis_ff, vis_in;
   logic [NW-1:0]       num [0:1];

   // whole pipeline moves together, held only by the output
   assign adv      = !v_ff[LAST] || out_ready;
   assign in_ready = adv;
   assign num[0]   = in_num_x;
   assign num[1]   = in_num_y;

   // overflow check, then one restoring step per stage, then saturation
   always_comb begin
      logic [DW:0]    r;
      logic           ge;
      logic [QW-1:0]  qv;
      logic [QW-1:0]  qneg;
      v_in = {v_ff[LAST-1:0], in_valid};
      d_in[0]    = in_den;
      side_in[0] = in_side;
      for (int k = 1; k <= QW; k++) begin
         d_in[k]    = d_ff[k-1];
         side_in[k] = side_ff[k-1];
      end
      for (int l = 0; l < 2; l++) begin
         ovf_in[l][0] = num[l][NW-1:QW] >= in_den;
         rem_in[l][0] = DW'(num[l][NW-1:QW]);
         nlo_in[l][0] = num[l][QW-1:0];
         q_in[l][0]   = '0;
         for (int k = 1; k <= QW; k++) begin
            r  = {rem_ff[l][k-1], nlo_ff[l][k-1][QW-k]};
            ge = r >= {1'b0, d_ff[k-1]};
            rem_in[l][k] = ge ? DW'(r - {1'b0, d_ff[k-1]}) : r[DW-1:0];
            q_in[l][k]   = {q_ff[l][k-1][QW-2:0], ge};
            nlo_in[l][k] = nlo_ff[l][k-1];
            ovf_in[l][k] = ovf_ff[l][k-1];
         end
         qv   = q_ff[l][QW];
         qneg = QW'(0) - qv;
         if (!side_ff[QW].visible) begin
            res_in[l] = '0;
         end else if (side_ff[QW].neg[l]) begin
            res_in[l] = (ovf_ff[l][QW] || qv > NEG_LIMIT) ?
                        NEG_LIMIT[COORD_WIDTH-1:0] : qneg[COORD_WIDTH-1:0];
         end else begin
            res_in[l] = (ovf_ff[l][QW] || qv > POS_LIMIT) ?
                        POS_LIMIT[COORD_WIDTH-1:0] : qv[COORD_WIDTH-1:0];
         end
      end
      vis_in = side_ff[QW].visible;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         nlo_ff  <= nlo_in;
         q_ff    <= q_in;
         ovf_ff  <= ovf_in;
         d_ff    <= d_in;
         side_ff <= side_in;
         res_ff  <= res_in;
         vis_ff  <= vis_in;
      end
   end

   assign out_valid   = v_ff[LAST];
   assign out_x       = res_ff[0];
   assign out_y       = res_ff[1];
   assign out_visible = vis_ff;

endmodule

`default_nettype wire

// ===== hdl/world_to_screen_projection.sv =====
`default_nettype none

// Perspective projection of world points to screen pixels. Takes one point
// (pos_x, pos_y, pos_z, signed Q format) per cycle and returns one result per
// point, in order. The pipeline has five front stages (products, clip sums,
// numerators, viewport scaling) and a restoring divider that resolves one
// quotient bit per stage for both axes in parallel, plus an overflow check and
// a saturation stage. A stalled output holds the whole pipeline. Points with
// clip w below 2.0 come out with visible low and zero coordinates. The user
// must write matrix rows and viewport size through the csr port only while no
// point is in flight; the block does not enforce this. Unknown indexes are
// ignored.
module world_to_screen_projection #(
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [95:0] req_tdata,   // pos_x, pos_y, pos_z
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // screen_x, screen_y
   output logic [0:0]  rsp_tuser,   // visible
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [3:0]  csr_index,
   input  wire  [63:0] csr_data
);

   localparam int unsigned PW  = 2*COORD_WIDTH;
   localparam int unsigned CS  = 2*COORD_WIDTH - FRAC_BITS + 2;
   localparam int unsigned MW  = CS + 1;
   localparam int unsigned DW  = CS;
   localparam int unsigned MH  = (MW + 1) / 2;
   localparam int unsigned DMW = wtsp_pkg::DIM_WIDTH;
   localparam int unsigned NW  = MW + DMW + FRAC_BITS;
   localparam logic signed [CS-1:0] W_MIN = CS'(2) << FRAC_BITS;

   // configuration registers
   logic [63:0]     m_ff [0:5];
   logic [DMW-1:0]  scr_w_ff, scr_h_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) m_ff[i] <= '0;
         scr_w_ff <= wtsp_pkg::SCREEN_WIDTH_RESET;
         scr_h_ff <= wtsp_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            wtsp_pkg::CSR_X_FIRST:  m_ff[0] <= csr_data;
            wtsp_pkg::CSR_X_SECOND: m_ff[1] <= csr_data;
            wtsp_pkg::CSR_Y_FIRST:  m_ff[2] <= csr_data;
            wtsp_pkg::CSR_Y_SECOND: m_ff[3] <= csr_data;
            wtsp_pkg::CSR_W_FIRST:  m_ff[4] <= csr_data;
            wtsp_pkg::CSR_W_SECOND: m_ff[5] <= csr_data;
            wtsp_pkg::CSR_WIDTH:    scr_w_ff <= csr_data[DMW-1:0];
            wtsp_pkg::CSR_HEIGHT:   scr_h_ff <= csr_data[DMW-1:0];
            default:                ;
         endcase
      end
   end

   // matrix entries, low and high half of each register
   logic signed [COORD_WIDTH-1:0] e_lo [0:5];
   logic signed [COORD_WIDTH-1:0] e_hi [0:5];
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         e_lo[i] = $signed(m_ff[i][COORD_WIDTH-1:0]);
         e_hi[i] = $signed(m_ff[i][32+COORD_WIDTH-1:32]);
      end
   end

   logic        adv;
   logic        div_ready;
   logic [5:1]  v_ff;

   assign adv        = div_ready;
   assign req_tready = adv;

   // stage 1: nine products
   logic signed [COORD_WIDTH-1:0] pos [0:2];
   logic signed [PW-1:0]          p_ff [0:8];
   logic signed [PW-1:0]          p_in [0:8];
   assign pos[0] = $signed(req_tdata[COORD_WIDTH-1:0]);
   assign pos[1] = $signed(req_tdata[32+COORD_WIDTH-1:32]);
   assign pos[2] = $signed(req_tdata[64+COORD_WIDTH-1:64]);
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         p_in[3*r]   = PW'(pos[0]) * PW'(e_lo[2*r]);
         p_in[3*r+1] = PW'(pos[1]) * PW'(e_hi[2*r]);
         p_in[3*r+2] = PW'(pos[2]) * PW'(e_lo[2*r+1]);
      end
   end

   // stage 2: floor shift and row sums
   logic signed [CS-1:0] c_ff [0:2];
   logic signed [CS-1:0] c_in [0:2];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         c_in[r] = CS'(p_ff[3*r] >>> FRAC_BITS) + CS'(p_ff[3*r+1] >>> FRAC_BITS)
                 + CS'(p_ff[3*r+2] >>> FRAC_BITS) + CS'(e_hi[2*r+1]);
      end
   end

   // stage 3: visibility, numerators, magnitudes, denominator
   logic signed [MW-1:0] nx, ny;
   logic                 vis3_in;
   logic [MW-1:0]        mag_ff [0:1];
   logic [MW-1:0]        mag_in [0:1];
   logic [DW-1:0]        d3_ff, d3_in;
   wtsp_pkg::side_type   s3_ff, s3_in;
   always_comb begin
      vis3_in = c_ff[2] >= W_MIN;
      nx = MW'(c_ff[0]) + MW'(c_ff[2]);
      ny = MW'(c_ff[2]) - MW'(c_ff[1]);
      mag_in[0] = !vis3_in ? '0 : (nx[MW-1] ? MW'(-nx) : MW'(nx));
      mag_in[1] = !vis3_in ? '0 : (ny[MW-1] ? MW'(-ny) : MW'(ny));
      d3_in = DW'(c_ff[2]) << 1;
      s3_in.visible = vis3_in;
      s3_in.neg     = {ny[MW-1], nx[MW-1]};
   end

   // stage 4: viewport scaling as two partial products per axis
   logic [MH+DMW-1:0]    plo_ff [0:1];
   logic [MH+DMW-1:0]    plo_in [0:1];
   logic [MW-MH+DMW-1:0] phi_ff [0:1];
   logic [MW-MH+DMW-1:0] phi_in [0:1];
   logic [DW-1:0]        d4_ff;
   wtsp_pkg::side_type   s4_ff;
   logic [DMW-1:0]       dim [0:1];
   assign dim[0] = scr_w_ff;
   assign dim[1] = scr_h_ff;
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         plo_in[l] = (MH+DMW)'(mag_ff[l][MH-1:0]) * (MH+DMW)'(dim[l]);
         phi_in[l] = (MW-MH+DMW)'(mag_ff[l][MW-1:MH]) * (MW-MH+DMW)'(dim[l]);
      end
   end

   // stage 5: combine partial products into the dividend
   logic [NW-1:0]      n_ff [0:1];
   logic [NW-1:0]      n_in [0:1];
   logic [DW-1:0]      d5_ff;
   wtsp_pkg::side_type s5_ff;
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         n_in[l] = ((NW'(phi_ff[l]) << MH) + NW'(plo_ff[l])) << FRAC_BITS;
      end
   end

   // front valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:1], req_tvalid};
      end
   end

   // front payload
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff   <= p_in;
         c_ff   <= c_in;
         mag_ff <= mag_in;
         d3_ff  <= d3_in;
         s3_ff  <= s3_in;
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         d4_ff  <= d3_ff;
         s4_ff  <= s3_ff;
         n_ff   <= n_in;
         d5_ff  <= d4_ff;
         s5_ff  <= s4_ff;
      end
   end

   // divider, saturation and output register
   logic [COORD_WIDTH-1:0] sx, sy;
   logic                   svis;

   wtsp_divpipe #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v_ff[5]),
      .in_ready    (div_ready),
      .in_num_x    (n_ff[0]),
      .in_num_y    (n_ff[1]),
      .in_den      (d5_ff),
      .in_side     (s5_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_x       (sx),
      .out_y       (sy),
      .out_visible (svis)
   );

   assign rsp_tdata = {32'(sy), 32'(sx)};
   assign rsp_tuser = svis;

   // hidden points carry zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("hidden point with nonzero coordinates");

   // an accepted point enters the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[1])
      else $error("accepted point lost at stage one");

   // a visible point never reaches the divider with a zero denominator
   assert property (@(posedge clock) disable iff (reset)
      v_ff[5] && s5_ff.visible |-> d5_ff != '0)
      else $error("visible point with zero denominator");

endmodule

`default_nettype wire

// ===== tb/world_to_screen_projection_test.sv =====
`timescale 1ns / 1ps

module world_to_screen_projection_test;

   localparam int IDLE_LIMIT  = 3000;
   localparam int DRAIN_WAIT  = 60;
   localparam int HOLD_CYCLES = 400;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [3:0]  CSR_UNKNOWN = 4'd9;

   typedef enum logic {ROW_CSR, ROW_POINT} row_kind_type;

   typedef struct packed {
      logic        visible;
      logic [31:0] sx;
      logic [31:0] sy;
   } screen_type;

   typedef struct {
      row_kind_type kind;
      logic [3:0]   idx;
      logic [63:0]  data;
      logic [31:0]  x, y, z;
      bit           typed;
      screen_type   want;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_index;
   logic [63:0] csr_data;

   // shadow copy of the block's registers
   logic [63:0]                    mat [6];
   logic [wtsp_pkg::DIM_WIDTH-1:0] dim_w, dim_h;

   screen_type expected_screen [$];
   int         errors;
   int         idle_cycles;
   bit         idle_on;
   bit         quiet;
   int         hold_count;
   row_type    directed [$];

   world_to_screen_projection u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one clip row: three floored products plus translation
   function automatic longint clip_row(logic [63:0] a, logic [63:0] b,
                                       logic [31:0] px, logic [31:0] py,
                                       logic [31:0] pz);
      longint s;
      s = (longint'($signed(px)) * longint'($signed(a[31:0]))) >>> 16;
      s += (longint'($signed(py)) * longint'($signed(a[63:32]))) >>> 16;
      s += (longint'($signed(pz)) * longint'($signed(b[31:0]))) >>> 16;
      return s + longint'($signed(b[63:32]));
   endfunction

   // n * (dim << 16) / d, truncated toward zero, saturated to 32 bits
   function automatic logic [31:0] viewport_scale(longint n,
                                                  logic [wtsp_pkg::DIM_WIDTH-1:0] dim,
                                                  longint d);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (n < 0) ? 128'(-n) : 128'(n);
      q = (mag * 128'({dim, 16'h0})) / 128'(d);
      if (n < 0)
         return (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(-q);
      return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
   endfunction

   function automatic screen_type project_point(logic [31:0] px, logic [31:0] py,
                                                logic [31:0] pz);
      longint     cx, cy, cw;
      screen_type r;
      cx = clip_row(mat[0], mat[1], px, py, pz);
      cy = clip_row(mat[2], mat[3], px, py, pz);
      cw = clip_row(mat[4], mat[5], px, py, pz);
      r = '0;
      if (cw >= (longint'(2) << 16)) begin
         r.visible = 1'b1;
         r.sx = viewport_scale(cx + cw, dim_w, cw * 2);
         r.sy = viewport_scale(cw - cy, dim_h, cw * 2);
      end
      return r;
   endfunction

   task automatic report(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
      errors++;
   endtask

   // result check
   always @(posedge clock) begin
      screen_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_screen.size() == 0) begin
            report("unexpected item", 32'h0, rsp_tdata[31:0]);
         end else begin
            w = expected_screen.pop_front();
            if (rsp_tuser[0] !== w.visible) report("visible", 32'(w.visible), 32'(rsp_tuser));
            if (rsp_tdata[31:0] !== w.sx) report("screen_x", w.sx, rsp_tdata[31:0]);
            if (rsp_tdata[63:32] !== w.sy) report("screen_y", w.sy, rsp_tdata[63:32]);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result ready: random stall bursts and a long hold when asked
   initial begin
      int hold_seen;
      int hold_left;
      int stall_left;
      hold_seen = 0;
      hold_left = 0;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_count != hold_seen) begin
            hold_seen = hold_count;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // offer one item; returns at the negedge after acceptance with valid still high
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             bit typed, screen_type want);
      int gap;
      if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {z, y, x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_screen.push_back(typed ? want : project_point(x, y, z));
      @(negedge clock);
   endtask

   // drop valid and wait for the pipeline to empty
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_screen.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // register write; leaves csr_valid high for back to back writes
   task automatic write_reg(logic [3:0] idx, logic [63:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx < wtsp_pkg::CSR_WIDTH) mat[idx] = data;
      else if (idx == wtsp_pkg::CSR_WIDTH) dim_w = data[wtsp_pkg::DIM_WIDTH-1:0];
      else if (idx == wtsp_pkg::CSR_HEIGHT) dim_h = data[wtsp_pkg::DIM_WIDTH-1:0];
      @(negedge clock);
   endtask

   function automatic logic [31:0] any_coord();
      if ($urandom_range(0, 9) < 7)
         return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
      return $urandom;
   endfunction

   function automatic logic [31:0] small_entry();
      return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
   endfunction

   function automatic row_type csr_row(logic [3:0] idx, logic [63:0] data);
      row_type r;
      r = '{kind: ROW_CSR, idx: idx, data: data, x: 0, y: 0, z: 0, typed: 0, want: '0};
      return r;
   endfunction

   function automatic row_type point_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         bit typed, screen_type want);
      row_type r;
      r = '{kind: ROW_POINT, idx: CSR_UNKNOWN, data: 0, x: x, y: y, z: z, typed: typed,
            want: want};
      return r;
   endfunction

   initial begin
      row_kind_type last_kind;
      logic [31:0]  tw;
      screen_type   hidden;
      screen_type   center;

      errors = 0;
      idle_cycles = 0;
      idle_on = 1'b0;
      quiet = 1'b0;
      hold_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      for (int i = 0; i < 6; i++) mat[i] = '0;
      dim_w = wtsp_pkg::SCREEN_WIDTH_RESET;
      dim_h = wtsp_pkg::SCREEN_HEIGHT_RESET;

      hidden = '0;
      center = '{visible: 1'b1, sx: 32'h0200_0000, sy: 32'h0180_0000};

      // after reset the matrix is zero, so clip w is zero: never visible
      directed.push_back(point_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, hidden));
      directed.push_back(point_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, hidden));
      directed.push_back(point_row(32'h0, 32'hFFFF_FFFF, 32'h0, 1, hidden));
      // translation alone of exactly 2.0: visible, viewport center
      directed.push_back(csr_row(wtsp_pkg::CSR_W_SECOND, {32'h0002_0000, 32'h0}));
      directed.push_back(point_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, center));
      directed.push_back(point_row(32'h0, 32'h0, 32'h0, 1, center));
      // one step below 2.0: not visible
      directed.push_back(csr_row(wtsp_pkg::CSR_W_SECOND, {32'h0001_FFFF, 32'h0}));
      directed.push_back(point_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1, hidden));
      // unknown index is ignored
      directed.push_back(csr_row(CSR_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF));
      directed.push_back(point_row(32'h0, 32'h0, 32'h0, 1, hidden));
      // identity rows, w fixed at 2.0: large points saturate both ways
      directed.push_back(csr_row(wtsp_pkg::CSR_X_FIRST, {32'h0, ONE}));
      directed.push_back(csr_row(wtsp_pkg::CSR_Y_FIRST, {ONE, 32'h0}));
      directed.push_back(csr_row(wtsp_pkg::CSR_W_SECOND, {32'h0002_0000, 32'h0}));
      directed.push_back(point_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 0, hidden));
      directed.push_back(point_row(32'h8000_0000, 32'h8000_0000, 32'h0, 0, hidden));
      directed.push_back(point_row(32'h0001_0000, 32'hFFFF_0000, 32'h0, 0, hidden));
      // extreme matrix entries
      directed.push_back(csr_row(wtsp_pkg::CSR_X_SECOND, {32'h7FFF_FFFF, 32'h8000_0000}));
      directed.push_back(csr_row(wtsp_pkg::CSR_W_FIRST, {32'h8000_0000, 32'h7FFF_FFFF}));
      directed.push_back(point_row(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 0, hidden));
      directed.push_back(point_row(32'h0, 32'h8000_0000, 32'h0, 0, hidden));
      directed.push_back(point_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, hidden));

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      last_kind = ROW_POINT;
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            if (last_kind == ROW_POINT) drain();
            write_reg(directed[i].idx, directed[i].data);
         end else begin
            if (last_kind == ROW_CSR) csr_valid <= 1'b0;
            send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].typed,
                       directed[i].want);
         end
         last_kind = directed[i].kind;
      end

      // random phases, each with a fresh setting of every register
      for (int p = 0; p < 9; p++) begin
         drain();
         idle_on = (p % 3) != 2;
         quiet = (p == 8);
         if (p == 4) begin
            for (int r = 0; r < 6; r++) write_reg(4'(r), {$urandom, $urandom});
         end else begin
            tw = 32'($urandom_range(2 * ONE, 200 * ONE));
            write_reg(wtsp_pkg::CSR_X_FIRST, {small_entry(), small_entry()});
            write_reg(wtsp_pkg::CSR_X_SECOND, {small_entry(), small_entry()});
            write_reg(wtsp_pkg::CSR_Y_FIRST, {small_entry(), small_entry()});
            write_reg(wtsp_pkg::CSR_Y_SECOND, {small_entry(), small_entry()});
            write_reg(wtsp_pkg::CSR_W_FIRST, {32'($signed(small_entry()) >>> 3),
                                              32'($signed(small_entry()) >>> 3)});
            write_reg(wtsp_pkg::CSR_W_SECOND,
                      {tw, ($urandom_range(0, 1) ? 32'hFFFF_0000 : ONE)});
         end
         case (p)
            1: begin
               write_reg(wtsp_pkg::CSR_WIDTH, 64'd8192);
               write_reg(wtsp_pkg::CSR_HEIGHT, 64'd8192);
            end
            2: begin
               write_reg(wtsp_pkg::CSR_WIDTH, 64'd1);
               write_reg(wtsp_pkg::CSR_HEIGHT, 64'd1);
            end
            3: begin
               write_reg(wtsp_pkg::CSR_WIDTH, 64'd0);
               write_reg(wtsp_pkg::CSR_HEIGHT, {$urandom, $urandom} | 64'h3FFF);
            end
            default: begin
               write_reg(wtsp_pkg::CSR_WIDTH, 64'($urandom_range(1, 8192)));
               write_reg(wtsp_pkg::CSR_HEIGHT, 64'($urandom_range(1, 8192)));
            end
         endcase
         write_reg(CSR_UNKNOWN, {$urandom, $urandom});
         csr_valid <= 1'b0;
         // long receiver hold while items keep coming
         if (p == 5) hold_count++;
         for (int n = 0; n < 100; n++)
            send_point(any_coord(), any_coord(), any_coord(), 0, hidden);
      end
      req_tvalid <= 1'b0;

      while (expected_screen.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
